### sv/assert_macros.svh
// Assertion macros shared by the RTL modules of the start code normalizer.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/asnc_pkg.sv
// Package of the start code normalizer: command record and sizes.
// Used by asnc_front, asnc_queue, asnc_back and the top level; depends on nothing.
package asnc_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOne  = 8'h01;

  // One classified input item: what the back end has to emit for it.
  typedef struct packed {
    logic       prefix;    // send 00 00 01 first
    logic [2:0] nzeros;    // zero payload bytes, 0 to 4
    logic       has_byte;  // then the payload byte below
    logic [7:0] data;
    logic       last;      // final command of the access unit
    logic       status;    // 1 when no NAL unit was found
  } cmd_t;

endpackage

### sv/annexb_start_code_normalizer.sv
// Top level of the Annex-B start code normalizer.
// Depends on asnc_pkg, asnc_front, asnc_queue and asnc_back.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tdata = in_byte, s_tlast = in_last
//   m_*      out  m_tvalid/m_tready   m_tdata = out_byte, m_tlast = out_last,
//                                     m_tuser = {out_status, out_has_byte}
//
// The front end takes one input byte per cycle whenever the four-entry command
// queue has room. The back end sends one output item per cycle while the output
// is taken, so an input byte that turns into one to seven items (a start code
// prefix included) holds the back end until all of them are sent; the queue
// absorbs those bursts and input stalls only when it fills up.
// Reset (rst, synchronous, active high) empties the queue and the output register
// and clears the scan state; no clearing pass follows.
// Either side may stall freely: the output register holds its item until taken.
module annexb_start_code_normalizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] out_has_byte, [1] out_status
);
  import asnc_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;
  logic has_byte;
  logic status;

  // Front end: tracks held zeros and start codes, one decision per input byte.
  asnc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (full),
    .in_ready (s_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Commands wait here so both sides can stall independently.
  asnc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back end: walks each command item by item into the output register.
  asnc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (m_tdata),
    .out_has_byte (has_byte),
    .out_last     (m_tlast),
    .out_status   (status)
  );

  assign m_tuser = {status, has_byte};

endmodule

### sv/asnc_front.sv
// Front end of the start code normalizer: scans input bytes and builds commands.
// Depends on asnc_pkg.
module asnc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push,
  output asnc_pkg::cmd_t    push_cmd
);
  import asnc_pkg::*;

  logic [1:0] pending_zeros, pending_zeros_next;
  logic       inside_nal, inside_nal_next;
  logic       prefix_pending, prefix_pending_next;
  logic       any_nal_seen, any_nal_seen_next;
  logic       accept;

  logic [2:0] zeros_out;
  logic       byte_out;
  logic       emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pending_zeros_next  = pending_zeros;
    inside_nal_next     = inside_nal;
    prefix_pending_next = prefix_pending;
    zeros_out           = 3'd0;
    byte_out            = 1'b0;

    if (in_byte == ByteZero) begin
      if (pending_zeros == 2'd3) begin
        // Long zero run: the oldest held zero becomes payload.
        zeros_out = 3'd1;
      end else begin
        pending_zeros_next = pending_zeros + 2'd1;
      end
    end else if (in_byte == ByteOne && pending_zeros >= 2'd2) begin
      pending_zeros_next  = 2'd0;
      inside_nal_next     = 1'b1;
      prefix_pending_next = 1'b1;
    end else begin
      zeros_out          = {1'b0, pending_zeros};
      byte_out           = 1'b1;
      pending_zeros_next = 2'd0;
    end

    if (in_last) begin
      zeros_out = zeros_out + {1'b0, pending_zeros_next};
    end

    // Outside a NAL unit no zeros and no payload byte are sent.
    if (!inside_nal) begin
      zeros_out = 3'd0;
      byte_out  = 1'b0;
    end

    emit = (zeros_out != 3'd0) || byte_out;
    if (emit) begin
      prefix_pending_next = 1'b0;
    end
    any_nal_seen_next = any_nal_seen || emit;

    push_cmd.prefix   = prefix_pending && emit;
    push_cmd.nzeros   = zeros_out;
    push_cmd.has_byte = byte_out;
    push_cmd.data     = byte_out ? in_byte : ByteZero;
    push_cmd.last     = in_last;
    push_cmd.status   = !any_nal_seen_next;
  end

  assign push = accept && (emit || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_zeros  <= 2'd0;
      inside_nal     <= 1'b0;
      prefix_pending <= 1'b0;
      any_nal_seen   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        pending_zeros  <= 2'd0;
        inside_nal     <= 1'b0;
        prefix_pending <= 1'b0;
        any_nal_seen   <= 1'b0;
      end else begin
        pending_zeros  <= pending_zeros_next;
        inside_nal     <= inside_nal_next;
        prefix_pending <= prefix_pending_next;
        any_nal_seen   <= any_nal_seen_next;
      end
    end
  end

endmodule

### sv/asnc_queue.sv
// Command queue between front and back end of the start code normalizer.
// Depends on asnc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module asnc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  asnc_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              q_valid,
  output asnc_pkg::cmd_t    q_cmd
);
  import asnc_pkg::*;

  cmd_t           entries [QDepth];
  logic [QAw-1:0] head;
  logic [QAw-1:0] tail;
  logic [QAw:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == (QAw+1)'(QDepth));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[head];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + 1'b1;
      end
      if (do_pop) begin
        head <= head + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= (QAw+1)'(QDepth), "queue count beyond depth")
  `ASSERT_IMPLIES(a_ptr_match, count == '0 || full, head == tail, "queue pointers disagree")

endmodule

### sv/asnc_back.sv
// Back end of the start code normalizer: expands commands into output bytes.
// Depends on asnc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module asnc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  asnc_pkg::cmd_t    q_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_has_byte,
  output logic              out_last,
  output logic              out_status
);
  import asnc_pkg::*;

  cmd_t       cmd;
  logic       busy;
  logic [2:0] idx;
  logic [3:0] total;
  logic [3:0] pre_len;
  logic [3:0] rel;
  logic       advance;
  logic       at_end;
  logic       step;

  logic [7:0] item_byte;
  logic       item_has;

  always_comb begin
    pre_len = cmd.prefix ? 4'd3 : 4'd0;
    total   = pre_len + {1'b0, cmd.nzeros} + {3'b000, cmd.has_byte};
    if (total == 4'd0) begin
      total = 4'd1;  // status-only end item
    end
    rel = {1'b0, idx} - pre_len;

    if (cmd.prefix && idx < 3'd3) begin
      item_byte = (idx == 3'd2) ? ByteOne : ByteZero;
      item_has  = 1'b1;
    end else if (rel < {1'b0, cmd.nzeros}) begin
      item_byte = ByteZero;
      item_has  = 1'b1;
    end else begin
      item_byte = cmd.data;
      item_has  = cmd.has_byte;
    end
  end

  assign advance = !out_valid || out_ready;
  assign step    = busy && advance;
  assign at_end  = ({1'b0, idx} == total - 4'd1);
  assign pop     = q_valid && (!busy || (step && at_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= 3'd0;
      end else if (step) begin
        if (at_end) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
      if (advance) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end
    if (step) begin
      out_byte     <= item_byte;
      out_has_byte <= item_has;
      out_last     <= cmd.last && at_end;
      out_status   <= cmd.last && at_end && cmd.status;
    end
  end

  `ASSERT_IMPLIES(a_idx_range, busy, {1'b0, idx} < total, "item index past command length")
  `ASSERT_IMPLIES(a_status_only, out_valid && !out_has_byte,
                  out_last && out_byte == ByteZero, "empty item that is not an end item")

endmodule
